// ----- src/h264sps_pkg.sv -----
package h264sps_pkg;

    localparam int DATA_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int PIXEL_W     = 21;
    localparam int CODE_W      = 8;
    localparam int ID_W        = 5;
    localparam int MBS_W       = 17;
    localparam int BITS_LEFT_W = 4;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_SPS   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_SCALING   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 3'd4;

    localparam logic [4:0] NAL_TYPE_SPS = 5'd7;

    localparam logic [CODE_W-1:0] PROFILE_HIGH     = 8'd100;
    localparam logic [CODE_W-1:0] PROFILE_HIGH10   = 8'd110;
    localparam logic [CODE_W-1:0] PROFILE_HIGH422  = 8'd122;
    localparam logic [CODE_W-1:0] PROFILE_HIGH444  = 8'd144;

    localparam int LIMIT_ID     = 31;
    localparam int LIMIT_CHROMA = 3;
    localparam int LIMIT_POC    = 2;
    localparam int LIMIT_CYCLE  = 255;
    localparam int LIMIT_MBS    = 65535;

    localparam int CHROMA_444   = 3;
    localparam int POC_TYPE_0   = 0;
    localparam int POC_TYPE_1   = 1;

    typedef enum logic [4:0] {
        ST_HDR, ST_PROF, ST_CONS, ST_LEVEL, ST_ID, ST_CHROMA, ST_RCT, ST_BDL,
        ST_BDC, ST_BYPASS, ST_SCAL, ST_LOG2FN, ST_POCT, ST_POCLSB, ST_DPAZ,
        ST_OFFNR, ST_OFFTB, ST_NCYC, ST_OFFREF, ST_NREF, ST_GAPS, ST_WIDTH,
        ST_HEIGHT, ST_DONE
    } step_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              last_byte;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PIXEL_W-1:0]  pixel_width;
        logic [PIXEL_W-1:0]  pixel_height;
        logic [CODE_W-1:0]   profile_code;
        logic [CODE_W-1:0]   level_code;
        logic [ID_W-1:0]     param_set_id;
    } out_item_t;

    // fixed field width of a step, zero for exp-golomb fields
    function automatic logic [BITS_LEFT_W-1:0] field_width(step_t s);
        logic [BITS_LEFT_W-1:0] w;
        unique case (s)
            ST_HDR, ST_PROF, ST_CONS, ST_LEVEL: w = 4'd8;
            ST_RCT, ST_BYPASS, ST_SCAL, ST_DPAZ, ST_GAPS: w = 4'd1;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

endpackage

// ----- src/h264sps_parser_core.sv -----
module h264sps_parser_core #(
    parameter int MAX_LEADING_ZEROS = 31
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  h264sps_pkg::in_item_t  item_in,
    output logic                   hit,
    output h264sps_pkg::out_item_t result
);
    import h264sps_pkg::*;

    localparam int ZC_W  = $clog2(MAX_LEADING_ZEROS + 1);
    localparam int ACC_W = MAX_LEADING_ZEROS + 1;

    step_t                  step_reg, step_next;
    logic                   gphase_reg, gphase_next;
    logic [ZC_W-1:0]        zc_reg, zc_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [BITS_LEFT_W-1:0] bl_reg, bl_next;
    logic [7:0]             cyc_reg, cyc_next;
    logic [CODE_W-1:0]      prof_reg, prof_next;
    logic [CODE_W-1:0]      lvl_reg, lvl_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic [MBS_W-1:0]       wmb_reg, wmb_next;
    logic                   sent_reg, sent_next;

    always_comb begin
        logic                bit_in;
        logic                fixed;
        logic                do_cmp;
        logic                fin;
        logic                go;
        logic [ACC_W-1:0]    v;
        step_t               nxt;
        logic [STATUS_W-1:0] fst;
        logic [MBS_W-1:0]    fin_h;
        logic [STATUS_W-1:0] res_status;
        logic [MBS_W-1:0]    res_h;
        logic                ok;

        step_next   = step_reg;
        gphase_next = gphase_reg;
        zc_next     = zc_reg;
        acc_next    = acc_reg;
        bl_next     = bl_reg;
        cyc_next    = cyc_reg;
        prof_next   = prof_reg;
        lvl_next    = lvl_reg;
        id_next     = id_reg;
        wmb_next    = wmb_reg;
        sent_next   = sent_reg;
        res_status  = STATUS_OK;
        res_h       = '0;
        hit         = 1'b0;
        bit_in      = 1'b0;
        fixed       = 1'b0;
        do_cmp      = 1'b0;
        fin         = 1'b0;
        go          = 1'b0;
        v           = '0;
        nxt         = ST_DONE;
        fst         = STATUS_OK;
        fin_h       = '0;

        // one bit step per data bit, msb first
        for (int i = 0; i < 8; i++) begin
            bit_in = item_in.data_byte[3'(7 - i)];
            fixed  = 1'b0;
            do_cmp = 1'b0;
            fin    = 1'b0;
            go     = 1'b0;
            v      = '0;
            nxt    = ST_DONE;
            fst    = STATUS_OK;
            fin_h  = '0;

            if (!sent_next && step_next != ST_DONE) begin
                fixed = (field_width(step_next) != '0);
                if (fixed) begin
                    acc_next = {acc_next[ACC_W-2:0], bit_in};
                    if (bl_next != '0) begin
                        bl_next = bl_next - 1'b1;
                    end
                    if (bl_next == '0) begin
                        do_cmp = 1'b1;
                        v      = acc_next;
                    end
                end else if (!gphase_next) begin
                    if (!bit_in) begin
                        if (zc_next >= ZC_W'(MAX_LEADING_ZEROS)) begin
                            fin = 1'b1;
                            fst = STATUS_RANGE;
                        end else begin
                            zc_next = zc_next + 1'b1;
                        end
                    end else if (zc_next == '0) begin
                        do_cmp = 1'b1;
                        v      = '0;
                    end else begin
                        gphase_next = 1'b1;
                        acc_next    = ACC_W'(1);
                    end
                end else begin
                    acc_next = {acc_next[ACC_W-2:0], bit_in};
                    zc_next  = zc_next - 1'b1;
                    if (zc_next == '0) begin
                        do_cmp = 1'b1;
                        v      = acc_next - ACC_W'(1);
                    end
                end
            end

            if (do_cmp) begin
                unique case (step_next)
                    ST_HDR: begin
                        if (v[4:0] != NAL_TYPE_SPS) begin
                            fin = 1'b1;
                            fst = STATUS_NOT_SPS;
                        end else begin
                            go = 1'b1; nxt = ST_PROF;
                        end
                    end
                    ST_PROF: begin
                        prof_next = v[CODE_W-1:0];
                        go = 1'b1; nxt = ST_CONS;
                    end
                    ST_CONS: begin go = 1'b1; nxt = ST_LEVEL; end
                    ST_LEVEL: begin
                        lvl_next = v[CODE_W-1:0];
                        go = 1'b1; nxt = ST_ID;
                    end
                    ST_ID: begin
                        if (v > ACC_W'(LIMIT_ID)) begin
                            fin = 1'b1; fst = STATUS_RANGE;
                        end else begin
                            id_next = v[ID_W-1:0];
                            go = 1'b1;
                            if (prof_next == PROFILE_HIGH || prof_next == PROFILE_HIGH10 ||
                                prof_next == PROFILE_HIGH422 || prof_next == PROFILE_HIGH444) begin
                                nxt = ST_CHROMA;
                            end else begin
                                nxt = ST_LOG2FN;
                            end
                        end
                    end
                    ST_CHROMA: begin
                        if (v > ACC_W'(LIMIT_CHROMA)) begin
                            fin = 1'b1; fst = STATUS_RANGE;
                        end else begin
                            go  = 1'b1;
                            nxt = (v == ACC_W'(CHROMA_444)) ? ST_RCT : ST_BDL;
                        end
                    end
                    ST_RCT:    begin go = 1'b1; nxt = ST_BDL; end
                    ST_BDL:    begin go = 1'b1; nxt = ST_BDC; end
                    ST_BDC:    begin go = 1'b1; nxt = ST_BYPASS; end
                    ST_BYPASS: begin go = 1'b1; nxt = ST_SCAL; end
                    ST_SCAL: begin
                        if (v != '0) begin
                            fin = 1'b1; fst = STATUS_SCALING;
                        end else begin
                            go = 1'b1; nxt = ST_LOG2FN;
                        end
                    end
                    ST_LOG2FN: begin go = 1'b1; nxt = ST_POCT; end
                    ST_POCT: begin
                        if (v > ACC_W'(LIMIT_POC)) begin
                            fin = 1'b1; fst = STATUS_RANGE;
                        end else begin
                            go = 1'b1;
                            if (v == ACC_W'(POC_TYPE_0)) begin
                                nxt = ST_POCLSB;
                            end else if (v == ACC_W'(POC_TYPE_1)) begin
                                nxt = ST_DPAZ;
                            end else begin
                                nxt = ST_NREF;
                            end
                        end
                    end
                    ST_POCLSB: begin go = 1'b1; nxt = ST_NREF; end
                    ST_DPAZ:   begin go = 1'b1; nxt = ST_OFFNR; end
                    ST_OFFNR:  begin go = 1'b1; nxt = ST_OFFTB; end
                    ST_OFFTB:  begin go = 1'b1; nxt = ST_NCYC; end
                    ST_NCYC: begin
                        if (v > ACC_W'(LIMIT_CYCLE)) begin
                            fin = 1'b1; fst = STATUS_RANGE;
                        end else begin
                            cyc_next = v[7:0];
                            go  = 1'b1;
                            nxt = (v == '0) ? ST_NREF : ST_OFFREF;
                        end
                    end
                    ST_OFFREF: begin
                        cyc_next = cyc_next - 8'd1;
                        go  = 1'b1;
                        nxt = (cyc_next == 8'd0) ? ST_NREF : ST_OFFREF;
                    end
                    ST_NREF: begin go = 1'b1; nxt = ST_GAPS; end
                    ST_GAPS: begin go = 1'b1; nxt = ST_WIDTH; end
                    ST_WIDTH: begin
                        if (v > ACC_W'(LIMIT_MBS)) begin
                            fin = 1'b1; fst = STATUS_RANGE;
                        end else begin
                            wmb_next = {1'b0, v[15:0]} + MBS_W'(1);
                            go = 1'b1; nxt = ST_HEIGHT;
                        end
                    end
                    ST_HEIGHT: begin
                        fin = 1'b1;
                        if (v > ACC_W'(LIMIT_MBS)) begin
                            fst = STATUS_RANGE;
                        end else begin
                            fst   = STATUS_OK;
                            fin_h = {1'b0, v[15:0]} + MBS_W'(1);
                        end
                    end
                    default: begin go = 1'b1; nxt = ST_DONE; end
                endcase
            end

            if (fin) begin
                res_status = fst;
                res_h      = fin_h;
                hit        = 1'b1;
                sent_next  = 1'b1;
                go         = 1'b1;
                nxt        = ST_DONE;
            end

            if (go) begin
                step_next   = nxt;
                bl_next     = field_width(nxt);
                acc_next    = '0;
                zc_next     = '0;
                gphase_next = 1'b0;
            end
        end

        if (item_in.last_byte && !sent_next) begin
            res_status = STATUS_TRUNCATED;
            res_h      = '0;
            hit        = 1'b1;
        end

        ok                  = (res_status == STATUS_OK);
        result.status       = res_status;
        result.pixel_width  = ok ? {wmb_next, 4'b0000} : '0;
        result.pixel_height = ok ? {res_h, 4'b0000} : '0;
        result.profile_code = prof_next;
        result.level_code   = lvl_next;
        result.param_set_id = id_next;

        // end of unit: back to the header for the next one
        if (item_in.last_byte) begin
            sent_next   = 1'b0;
            cyc_next    = '0;
            prof_next   = '0;
            lvl_next    = '0;
            id_next     = '0;
            wmb_next    = '0;
            step_next   = ST_HDR;
            bl_next     = field_width(ST_HDR);
            acc_next    = '0;
            zc_next     = '0;
            gphase_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= ST_HDR;
            gphase_reg <= 1'b0;
            zc_reg     <= '0;
            acc_reg    <= '0;
            bl_reg     <= field_width(ST_HDR);
            cyc_reg    <= '0;
            prof_reg   <= '0;
            lvl_reg    <= '0;
            id_reg     <= '0;
            wmb_reg    <= '0;
            sent_reg   <= 1'b0;
        end else if (en) begin
            step_reg   <= step_next;
            gphase_reg <= gphase_next;
            zc_reg     <= zc_next;
            acc_reg    <= acc_next;
            bl_reg     <= bl_next;
            cyc_reg    <= cyc_next;
            prof_reg   <= prof_next;
            lvl_reg    <= lvl_next;
            id_reg     <= id_next;
            wmb_reg    <= wmb_next;
            sent_reg   <= sent_next;
        end
    end

endmodule

// ----- src/h264_sps_size_parser_top.sv -----
// a byte is held in the input register; any result it gives is registered onto m_item
// one byte per cycle unless stalled; a byte's eight bit steps are combinational
// a byte waits in the input register only while the result register is full and not taken
// reset: aresetn low at a clock edge empties both registers and returns the parser
// to the nal header step with all held fields cleared
module h264_sps_size_parser_top #(
    parameter int MAX_LEADING_ZEROS = 31
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  h264sps_pkg::in_item_t  s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output h264sps_pkg::out_item_t m_item
);
    import h264sps_pkg::*;

    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;
    logic      advance;
    logic      hit;
    out_item_t result;

    // the held item moves on once the result register has room
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    h264sps_parser_core #(
        .MAX_LEADING_ZEROS(MAX_LEADING_ZEROS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .item_in (in_item_reg),
        .hit     (hit),
        .result  (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance && hit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance && hit) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule
